// File: rtl/tlbdp_pkg.sv
`timescale 1ns / 1ps

package tlbdp_pkg;

    // Fixed address format.
    localparam int VA_WIDTH       = 16;
    localparam int PA_WIDTH       = 16;
    // Page number bits left above the narrowest supported offset.
    localparam int RAW_PAGE_WIDTH = 12;
    localparam int RAW_PAGE_MAX   = (1 << RAW_PAGE_WIDTH) - 1;
    // Quotient bits of the raw page number over the smallest page count.
    localparam int MOD_STEPS      = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_TLB_ENTRIES     = 16;
    localparam int DEF_PAGE_COUNT      = 256;
    localparam int DEF_OFFSET_WIDTH    = 8;
    localparam int DEF_USE_COUNT_WIDTH = 16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } tlbdp_state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic scan_step;
        logic update;
        logic load_out;
        logic clear_step;
    } tlbdp_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_last;
        logic clear_last;
    } tlbdp_status_t;

endpackage

// File: rtl/tlbdp_ctrl.sv
`timescale 1ns / 1ps

module tlbdp_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    out_stall,
    input  tlbdp_pkg::tlbdp_status_t status,
    output logic                    in_stall,
    output logic                    out_valid,
    output tlbdp_pkg::tlbdp_cmd_t   cmd
);
    import tlbdp_pkg::*;

    tlbdp_state_t state_reg;
    tlbdp_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_free;

    // The output register can take a new item when empty or being drained now.
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (status.hit)
                    state_next = ST_FINISH;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = in_valid ? ST_LOOKUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == ST_FINISH && out_free)
            out_valid_next = 1'b1;
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear_step = 1'b1;
            ST_IDLE:   in_stall       = 1'b0;
            ST_LOOKUP: cmd.lookup     = 1'b1;
            ST_SCAN:   cmd.scan_step  = 1'b1;
            ST_UPDATE: cmd.update     = 1'b1;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    in_stall     = 1'b0;
                end
            end
            default:   in_stall       = 1'b1;
        endcase
        cmd.capture = in_valid && !in_stall;
    end

endmodule

// File: rtl/tlbdp_datapath.sv
`timescale 1ns / 1ps

module tlbdp_datapath #(
    parameter int TLB_ENTRIES     = tlbdp_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT      = tlbdp_pkg::DEF_PAGE_COUNT,
    parameter int OFFSET_WIDTH    = tlbdp_pkg::DEF_OFFSET_WIDTH,
    parameter int USE_COUNT_WIDTH = tlbdp_pkg::DEF_USE_COUNT_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tlbdp_pkg::tlbdp_cmd_t            cmd,
    input  logic [tlbdp_pkg::VA_WIDTH-1:0]   virtual_address,
    output tlbdp_pkg::tlbdp_status_t         status,
    output logic [tlbdp_pkg::PA_WIDTH-1:0]   physical_address,
    output logic                             tlb_hit,
    output logic                             page_fault
);
    import tlbdp_pkg::*;

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam int PW    = $clog2(PAGE_COUNT);
    localparam int NFW   = $clog2(PAGE_COUNT + 1);
    localparam int CW    = USE_COUNT_WIDTH;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // Page number modulo the page count by restoring subtraction of the
    // shifted constant; the quotient has at most MOD_STEPS bits.
    function automatic logic [RAW_PAGE_WIDTH-1:0] page_mod(
        input logic [RAW_PAGE_WIDTH-1:0] raw
    );
        logic [RAW_PAGE_WIDTH-1:0] r;
        r = raw;
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            if ((PAGE_COUNT << k) <= RAW_PAGE_MAX)
            begin
                if (r >= RAW_PAGE_WIDTH'(PAGE_COUNT << k))
                    r = r - RAW_PAGE_WIDTH'(PAGE_COUNT << k);
            end
        end
        return r;
    endfunction

    logic [RAW_PAGE_WIDTH-1:0] page_raw;
    logic [RAW_PAGE_WIDTH-1:0] page_rem;
    logic [PW-1:0]             page_in;

    logic [PW-1:0]             page_reg;
    logic [OFFSET_WIDTH-1:0]   offset_reg;

    // TLB entries: tags are compared in parallel, one frame and one count
    // are read through the entry index.
    logic [PW-1:0]             tag_reg   [TLB_ENTRIES];
    logic [PW-1:0]             frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]    valid_reg;
    logic [CW-1:0]             count_reg [TLB_ENTRIES];

    // Page table.
    logic [PW-1:0]             pt_frame_mem   [PAGE_COUNT];
    logic                      pt_present_mem [PAGE_COUNT];
    logic [PW-1:0]             pt_frame_q;
    logic                      pt_present_q;
    logic [PW-1:0]             pt_wr_addr;
    logic                      pt_present_wr;
    logic [PW-1:0]             clear_idx_reg;

    logic [NFW-1:0]            nff_reg;
    logic [PW-1:0]             alloc_frame;
    logic [PW-1:0]             miss_frame;
    logic                      fault;

    logic                      hit_any;
    logic [IDX_W-1:0]          hit_idx;

    logic [IDX_W-1:0]          scan_idx_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic [CW-1:0]             best_cnt_reg;

    logic [PW-1:0]             res_frame_reg;
    logic                      res_hit_reg;
    logic                      res_fault_reg;
    logic [31:0]               phys_wide;

    assign page_raw = RAW_PAGE_WIDTH'(virtual_address >> OFFSET_WIDTH);
    assign page_rem = page_mod(page_raw);
    assign page_in  = page_rem[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg   <= page_in;
            offset_reg <= virtual_address[OFFSET_WIDTH-1:0];
        end
    end

    // Lowest matching entry wins.
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--)
        begin
            if (valid_reg[k] && tag_reg[k] == page_reg)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    // A frame number equal to the page count wraps to zero.
    assign alloc_frame = (nff_reg == NFW'(PAGE_COUNT)) ? '0 : nff_reg[PW-1:0];
    assign miss_frame  = pt_present_q ? pt_frame_q : alloc_frame;
    assign fault       = !pt_present_q;

    assign status.hit        = hit_any;
    assign status.scan_last  = (scan_idx_reg == IDX_W'(TLB_ENTRIES - 1));
    assign status.clear_last = (clear_idx_reg == PW'(PAGE_COUNT - 1));

    // Page table: one write port, one registered read port.
    assign pt_wr_addr    = cmd.clear_step ? clear_idx_reg : page_reg;
    assign pt_present_wr = !cmd.clear_step;

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step || (cmd.update && fault))
            pt_present_mem[pt_wr_addr] <= pt_present_wr;
        if (cmd.capture)
            pt_present_q <= pt_present_mem[page_in];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && fault)
            pt_frame_mem[page_reg] <= alloc_frame;
        if (cmd.capture)
            pt_frame_q <= pt_frame_mem[page_in];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_idx_reg <= '0;
            nff_reg       <= '0;
        end
        else
        begin
            if (cmd.clear_step)
                clear_idx_reg <= clear_idx_reg + 1'b1;
            if (cmd.update && fault && nff_reg != NFW'(PAGE_COUNT))
                nff_reg <= nff_reg + 1'b1;
        end
    end

    // Victim search: one use count compared per cycle, strict less-than keeps
    // the lowest index on ties. Counts do not change until the update.
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            scan_idx_reg <= IDX_W'(1);
            best_idx_reg <= '0;
            best_cnt_reg <= count_reg[0];
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (count_reg[scan_idx_reg] < best_cnt_reg)
            begin
                best_idx_reg <= scan_idx_reg;
                best_cnt_reg <= count_reg[scan_idx_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            tag_reg[best_idx_reg]   <= page_reg;
            frame_reg[best_idx_reg] <= miss_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int k = 0; k < TLB_ENTRIES; k++)
                count_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < TLB_ENTRIES; k++)
            begin
                if (cmd.update && best_idx_reg == IDX_W'(k))
                    valid_reg[k] <= 1'b1;
                if ((cmd.lookup && hit_any && hit_idx == IDX_W'(k)) ||
                    (cmd.update && best_idx_reg == IDX_W'(k)))
                begin
                    if (count_reg[k] != CNT_MAX)
                        count_reg[k] <= count_reg[k] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup && hit_any)
        begin
            res_frame_reg <= frame_reg[hit_idx];
            res_hit_reg   <= 1'b1;
            res_fault_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            res_frame_reg <= miss_frame;
            res_hit_reg   <= 1'b0;
            res_fault_reg <= fault;
        end
    end

    assign phys_wide = (32'(res_frame_reg) << OFFSET_WIDTH) | 32'(offset_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            physical_address <= phys_wide[PA_WIDTH-1:0];
            tlb_hit          <= res_hit_reg;
            page_fault       <= res_fault_reg;
        end
    end

endmodule

// File: rtl/tlb_translate_with_demand_paging.sv
`timescale 1ns / 1ps

// Translates a 16-bit virtual address through a fully associative TLB with
// least-frequently-used replacement, falling back to a demand-paged page
// table that hands out frames in order on first touch. Each item gives one
// result with the physical address, a TLB hit flag and a page fault flag.
// A TLB hit goes through the tag compare followed by the result register.
// A miss also runs the victim search, which compares one entry's use
// count per cycle before the entry is rewritten. The page table read is
// issued as the item is accepted and overlaps the lookup. After reset the
// block clears the page-present memory and accepts no item until it is
// done. A finished result may wait in the output register while the next
// item is taken in.
module tlb_translate_with_demand_paging #(
    parameter int TLB_ENTRIES     = tlbdp_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT      = tlbdp_pkg::DEF_PAGE_COUNT,
    parameter int OFFSET_WIDTH    = tlbdp_pkg::DEF_OFFSET_WIDTH,
    parameter int USE_COUNT_WIDTH = tlbdp_pkg::DEF_USE_COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tlbdp_pkg::VA_WIDTH-1:0] virtual_address,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tlbdp_pkg::PA_WIDTH-1:0] physical_address,
    output logic                           tlb_hit,
    output logic                           page_fault
);
    import tlbdp_pkg::*;

    tlbdp_cmd_t    cmd;
    tlbdp_status_t status;

    tlbdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    tlbdp_datapath #(
        .TLB_ENTRIES     (TLB_ENTRIES),
        .PAGE_COUNT      (PAGE_COUNT),
        .OFFSET_WIDTH    (OFFSET_WIDTH),
        .USE_COUNT_WIDTH (USE_COUNT_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .virtual_address  (virtual_address),
        .status           (status),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault)
    );

endmodule

// File: rtl/tlbdp_checker.sv
`timescale 1ns / 1ps

module tlbdp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [tlbdp_pkg::VA_WIDTH-1:0] virtual_address,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [tlbdp_pkg::PA_WIDTH-1:0] physical_address,
    input logic                           tlb_hit,
    input logic                           page_fault
);

    // A page found in the TLB can never also be a fresh fault.
    a_hit_excludes_fault: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tlb_hit && page_fault)
    ) else $error("hit and page fault reported together");

    // One item at a time: the cycle after an item is taken the block is busy.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("second item taken right after the first");

    // The result flags only change along with a new result.
    a_flags_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(tlb_hit) && $stable(page_fault))
    ) else $error("stalled result flags changed");

    // A stalled physical address holds.
    a_addr_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(physical_address)
    ) else $error("stalled physical address changed");

endmodule

bind tlb_translate_with_demand_paging tlbdp_checker u_tlbdp_checker (.*);

// File: dv/tlbdp_translation_checker.sv
`timescale 1ns / 1ps

module tlbdp_translation_checker #(
    parameter int TLB_ENTRIES     = tlbdp_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT      = tlbdp_pkg::DEF_PAGE_COUNT,
    parameter int OFFSET_WIDTH    = tlbdp_pkg::DEF_OFFSET_WIDTH,
    parameter int USE_COUNT_WIDTH = tlbdp_pkg::DEF_USE_COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [tlbdp_pkg::VA_WIDTH-1:0] virtual_address,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [tlbdp_pkg::PA_WIDTH-1:0] physical_address,
    input  logic                           tlb_hit,
    input  logic                           page_fault,
    output int                             mismatches,
    output int                             awaited
);

    import tlbdp_pkg::*;

    localparam logic [USE_COUNT_WIDTH-1:0] COUNT_TOP = '1;
    localparam int OFFSET_MASK = (1 << OFFSET_WIDTH) - 1;

    typedef struct packed {
        logic [PA_WIDTH-1:0] pa;
        logic                hit;
        logic                fault;
    } translation_t;

    int                         entry_page  [TLB_ENTRIES];
    int                         entry_frame [TLB_ENTRIES];
    bit                         entry_valid [TLB_ENTRIES];
    logic [USE_COUNT_WIDTH-1:0] entry_uses  [TLB_ENTRIES];
    int                         frame_of_page [PAGE_COUNT];
    bit                         page_mapped   [PAGE_COUNT];
    int                         frames_handed;
    translation_t               expected_translations [$];
    translation_t               want;

    function automatic void bump_uses(input int slot);
        if (entry_uses[slot] != COUNT_TOP)
            entry_uses[slot] = entry_uses[slot] + 1'b1;
    endfunction

    // Walks the TLB and the page table exactly as the block should, updating
    // the shadow state, and returns the translation that must come out.
    function automatic translation_t translate_address(input logic [VA_WIDTH-1:0] va);
        int           page;
        int           frame;
        int           slot;
        int           victim;
        int           k;
        translation_t r;
        page  = (int'(va) >> OFFSET_WIDTH) % PAGE_COUNT;
        slot  = -1;
        frame = 0;
        r     = '0;
        for (k = 0; k < TLB_ENTRIES; k++)
        begin
            if (slot < 0 && entry_valid[k] && entry_page[k] == page)
                slot = k;
        end
        if (slot >= 0)
        begin
            r.hit = 1'b1;
            frame = entry_frame[slot];
            bump_uses(slot);
        end
        else
        begin
            if (page_mapped[page])
            begin
                frame = frame_of_page[page];
            end
            else
            begin
                r.fault = 1'b1;
                frame   = frames_handed % PAGE_COUNT;
                if (frames_handed < PAGE_COUNT)
                    frames_handed++;
                frame_of_page[page] = frame;
                page_mapped[page]   = 1'b1;
            end
            // Least used entry wins, lowest index on a tie.
            victim = 0;
            for (k = 1; k < TLB_ENTRIES; k++)
            begin
                if (entry_uses[k] < entry_uses[victim])
                    victim = k;
            end
            entry_page[victim]  = page;
            entry_frame[victim] = frame;
            entry_valid[victim] = 1'b1;
            bump_uses(victim);
        end
        r.pa = PA_WIDTH'((frame << OFFSET_WIDTH) | (int'(va) & OFFSET_MASK));
        return r;
    endfunction

    task automatic flag_field(input string field, input int exp_val, input int act_val);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (entry_valid[k])
            begin
                entry_valid[k] = 1'b0;
                entry_uses[k]  = '0;
                entry_page[k]  = 0;
                entry_frame[k] = 0;
            end
            foreach (page_mapped[p])
            begin
                page_mapped[p]   = 1'b0;
                frame_of_page[p] = 0;
            end
            frames_handed = 0;
            expected_translations.delete();
            mismatches = 0;
            awaited    = 0;
        end
        else
        begin
            // A result leaving in this cycle belongs to an earlier item, so it
            // is checked before the item entering in the same cycle is added.
            if (out_valid && !out_stall)
            begin
                if (expected_translations.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual pa=%h hit=%b fault=%b",
                             $time, physical_address, tlb_hit, page_fault);
                    mismatches++;
                end
                else
                begin
                    want = expected_translations.pop_front();
                    if (physical_address !== want.pa)
                        flag_field("physical_address", want.pa, physical_address);
                    if (tlb_hit !== want.hit)
                        flag_field("tlb_hit", want.hit, tlb_hit);
                    if (page_fault !== want.fault)
                        flag_field("page_fault", want.fault, page_fault);
                end
            end
            if (in_valid && !in_stall)
                expected_translations.push_back(translate_address(virtual_address));
            awaited = expected_translations.size();
        end
    end

endmodule

// File: dv/tb_tlb_translate_with_demand_paging.sv
`timescale 1ns / 1ps

module tb_tlb_translate_with_demand_paging;

    import tlbdp_pkg::*;

    // Enough hits on one page to lift its use count well above the others.
    localparam int HAMMER_HITS  = 40;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOT_PAGES    = 24;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [VA_WIDTH-1:0] virtual_address;
    logic                out_valid;
    logic                out_stall;
    logic [PA_WIDTH-1:0] physical_address;
    logic                tlb_hit;
    logic                page_fault;
    int                  mismatches;
    int                  awaited;
    bit                  no_idle;
    bit                  hold_request;

    tlb_translate_with_demand_paging dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .virtual_address  (virtual_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault)
    );

    tlbdp_translation_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .virtual_address  (virtual_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .mismatches       (mismatches),
        .awaited          (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_address(input logic [VA_WIDTH-1:0] va);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        virtual_address <= va;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: a random hold-off before each item, and one long hold-off
    // on request so that the block backs up into its input.
    initial
    begin
        int n;
        bit held;
        out_stall = 1'b0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = idle_draw();
            if (hold_request && !held)
            begin
                n    = 150;
                held = 1'b1;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        logic [7:0] hot_pages [HOT_PAGES];
        logic [7:0] page;
        logic [7:0] hammered;
        int         i;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        virtual_address = '0;
        no_idle         = 1'b0;
        hold_request    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Address extremes, a quick re-hit of each, then enough new pages to
        // force the first evictions.
        send_address(16'h0000);
        send_address(16'hFFFF);
        send_address(16'h00A5);
        send_address(16'hFF5A);
        for (i = 1; i <= 16; i++)
            send_address({8'(i), 8'(i * 17)});
        send_address(16'h00FF);
        send_address(16'hFF00);

        // Hammer one page, then push enough misses through that only the
        // least used entries get evicted and the hammered page survives.
        no_idle  = 1'b1;
        hammered = 8'h3C;
        for (i = 0; i < HAMMER_HITS; i++)
            send_address({hammered, 8'($urandom)});
        for (i = 0; i < 2 * DEF_TLB_ENTRIES; i++)
            send_address({8'(8'h80 + i), 8'($urandom)});
        send_address({hammered, 8'($urandom)});
        no_idle = 1'b0;

        // Mostly a hot working set so that hits and LFU eviction dominate,
        // with uniform pages mixed in and the set drifting over time.
        foreach (hot_pages[k])
            hot_pages[k] = 8'($urandom);
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (i % 25 == 0)
                hot_pages[$urandom_range(0, HOT_PAGES - 1)] = 8'($urandom);
            if (i == 100)
                hold_request = 1'b1;
            if ($urandom_range(0, 9) < 7)
                page = hot_pages[$urandom_range(0, HOT_PAGES - 1)];
            else
                page = 8'($urandom);
            send_address({page, 8'($urandom)});
        end
        in_valid <= 1'b0;

        wait (awaited == 0);
        repeat (DEF_TLB_ENTRIES + 8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_tlb_translate_with_demand_paging OK");
        else
            $display("tb_tlb_translate_with_demand_paging NOT OK");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("tb_tlb_translate_with_demand_paging NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tlbdp_pkg.sv
rtl/tlbdp_ctrl.sv
rtl/tlbdp_datapath.sv
rtl/tlb_translate_with_demand_paging.sv
rtl/tlbdp_checker.sv
dv/tlbdp_translation_checker.sv
dv/tb_tlb_translate_with_demand_paging.sv
